[rtl/free_list_heap_allocator_assert.svh]
// Assertion macros for the free-list heap allocator.
// Used by the RTL files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef FREE_LIST_HEAP_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check that is switched off while reset is asserted.
`define FLHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that also holds while reset is asserted.
`define FLHA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FLHA_ASSERT(lbl, prop, msg)
`define FLHA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/flha_pkg.sv]
// Shared types and constants of the free-list heap allocator.
// No dependencies; imported by flha_alu, the top level and the testbench, not by flha_ram.
`timescale 1ns / 1ps

package flha_pkg;

  // Width of the shared adder/comparator; covers unit indexes of the largest arena.
  localparam int ALU_W = 24;

  // Every block header is this many bytes before rounding to whole units.
  localparam int HEADER_BYTES = 16;

  localparam logic [1:0] FP_FIRST = 2'd0;
  localparam logic [1:0] FP_BEST  = 2'd1;
  localparam logic [1:0] FP_WORST = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_SIZE   = 2'd2,
    OP_REINIT = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_OUTZONE = 3'd2,
    ST_INVALID = 3'd3,
    ST_ALREADY = 3'd4,
    ST_CORRUPT = 3'd5
  } status_e;

  // Operands of the shared unit: sum = a + b, compared against c.
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             lt;
    logic             eq;
  } alu_rsp_t;

endpackage

[rtl/flha_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module flha_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/flha_alu.sv]
// Shared add-and-compare unit of the allocator sequencer.
// Depends on flha_pkg for the operand and result structs.
`timescale 1ns / 1ps

module flha_alu (
  input  flha_pkg::alu_req_t req_i,
  output flha_pkg::alu_rsp_t rsp_o
);
  import flha_pkg::*;

  logic [ALU_W-1:0] sum;

  assign sum       = req_i.a + req_i.b;
  assign rsp_o.sum = sum;
  assign rsp_o.lt  = (sum < req_i.c);
  assign rsp_o.eq  = (sum == req_i.c);

endmodule

[rtl/free_list_heap_allocator.sv]
// Top level of the free-list heap allocator: sequencer, header stores and result register.
// Depends on flha_pkg, flha_ram, flha_alu and free_list_heap_allocator_assert.svh.
//
//  Channel  Direction  Handshake                  Word
//  in       to block   in_valid_i / in_ready_o    opcode, request size, zone address
//  out      from block out_valid_o / out_ready_i  result address, result size, status
//  cfg      to block   cfg_valid_i / cfg_ready_o  fit policy (2 bits)
//
// After reset the header stores are swept to zero, one unit per cycle over all ARENA_BYTES /
// ALIGN_BYTES units (4096 at the defaults), then the arena block is written; no request
// is taken meanwhile. An allocate reads one header per free block visited, and a free
// that walks the list reads one per block walked; get-size and reinitialize walk no list,
// and all are paced by the registered read of the header stores. One request is in flight
// at a time; its result waits in the output register.
`timescale 1ns / 1ps
`include "free_list_heap_allocator_assert.svh"

module free_list_heap_allocator #(
  parameter int ARENA_BYTES = 65536,
  parameter int ALIGN_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] zone_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_address_o,
  output logic [15:0] result_size_o,
  output logic [2:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);
  import flha_pkg::*;

  localparam int NUNITS = ARENA_BYTES / ALIGN_BYTES;
  localparam int SH     = $clog2(ALIGN_BYTES);
  localparam int HDR    = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int UW     = $clog2(NUNITS + 1);
  localparam int IW     = $clog2(NUNITS);
  localparam int ZMIN   = HDR * ALIGN_BYTES;

  localparam logic [UW-1:0] NUNITS_U = UW'(NUNITS);
  localparam logic [UW-1:0] HDR_U    = UW'(HDR);

  // One-hot sequencer states.
  typedef enum logic [20:0] {
    S_CLEAR   = 21'h000001,
    S_INIT    = 21'h000002,
    S_IDLE    = 21'h000004,
    S_A_READ  = 21'h000008,
    S_A_CHK   = 21'h000010,
    S_A_END   = 21'h000020,
    S_A_PICK  = 21'h000040,
    S_A_SPLIT = 21'h000080,
    S_A_W1    = 21'h000100,
    S_A_W2    = 21'h000200,
    S_F_START = 21'h000400,
    S_F_B     = 21'h000800,
    S_F_RD    = 21'h001000,
    S_F_EV    = 21'h002000,
    S_F_FIN   = 21'h004000,
    S_F_L2    = 21'h008000,
    S_M_RD    = 21'h010000,
    S_M_CHK   = 21'h020000,
    S_M_LEFT  = 21'h040000,
    S_RESP    = 21'h080000,
    S_SPARE   = 21'h100000
  } state_e;

  state_e state_q, state_d;

  // Control registers.
  logic [UW-1:0]    free_head_q, free_head_d;
  logic [1:0]       policy_q, policy_d;
  logic [IW-1:0]    clr_q, clr_d;
  logic             reinit_q, reinit_d;
  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  logic             first_q, first_d;
  logic             left_q, left_d;
  logic             split_q, split_d;
  logic [UW-1:0]    count_q, count_d;

  // Working registers of the current request.
  opcode_e          op_q, op_d;
  logic [15:0]      zone_q, zone_d;
  logic [ALU_W-1:0] want_q, want_d;
  logic [UW-1:0]    cur_q, cur_d;
  logic [UW-1:0]    prev_q, prev_d;
  logic [UW-1:0]    pick_q, pick_d;
  logic [UW-1:0]    pick_prev_q, pick_prev_d;
  logic [UW-1:0]    pick_size_q, pick_size_d;
  logic [UW-1:0]    nxp_q, nxp_d;
  logic [UW-1:0]    link_q, link_d;
  logic [UW-1:0]    real_q, real_d;
  logic [UW-1:0]    b_q, b_d;
  logic [UW-1:0]    sb_q, sb_d;
  logic [UW-1:0]    nb_q, nb_d;
  logic [UW-1:0]    p_q, p_d;
  logic [UW-1:0]    sp_q, sp_d;
  logic [15:0]      res_addr_q, res_addr_d;
  logic [15:0]      res_size_q, res_size_d;
  status_e          res_st_q, res_st_d;
  logic [15:0]      out_addr_q, out_addr_d;
  logic [15:0]      out_size_q, out_size_d;
  logic [2:0]       out_st_q, out_st_d;

  // Header store ports.
  logic             size_we, next_we;
  logic [IW-1:0]    size_waddr, next_waddr, raddr;
  logic [UW-1:0]    size_wdata, next_wdata, size_rd, next_rd;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  // Address arithmetic that stays local to one state.
  logic [16:0]      zone_units;
  logic [UW+SH-1:0] usable_bytes;
  logic [UW-1:0]    nf;
  logic             fit, take, corrupt_a;

  flha_ram #(.WIDTH(UW), .DEPTH(NUNITS)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (size_waddr),
    .wdata_i (size_wdata),
    .raddr_i (raddr),
    .rdata_o (size_rd)
  );

  flha_ram #(.WIDTH(UW), .DEPTH(NUNITS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (raddr),
    .rdata_o (next_rd)
  );

  flha_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_ready_o       = (state_q == S_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign result_size_o    = out_size_q;
  assign status_o         = out_st_q;

  assign zone_units   = 17'(zone_q >> SH);
  assign usable_bytes = (UW+SH)'(size_rd - HDR_U) << SH;
  assign nf           = alu_rsp.sum[UW-1:0];
  assign fit          = (ALU_W'(size_rd) >= want_q);

  // Shared unit operands follow the sequencer state.
  always_comb begin
    alu_req = '0;
    case (state_q)
      S_A_CHK: begin
        alu_req.a = ALU_W'(cur_q);
        alu_req.b = ALU_W'(size_rd);
        alu_req.c = ALU_W'(NUNITS + 1);
      end
      S_A_SPLIT: begin
        alu_req.a = want_q;
        alu_req.b = ALU_W'(HDR);
        alu_req.c = ALU_W'(pick_size_q);
      end
      S_A_W1: begin
        alu_req.a = ALU_W'(pick_q);
        alu_req.b = want_q;
      end
      S_F_EV: begin
        alu_req.a = ALU_W'(p_q);
        alu_req.b = ALU_W'(size_rd);
        alu_req.c = ALU_W'(b_q);
      end
      S_F_FIN, S_M_LEFT: begin
        alu_req.a = ALU_W'(p_q);
        alu_req.b = ALU_W'(sp_q);
        alu_req.c = ALU_W'(b_q);
      end
      S_M_CHK: begin
        alu_req.a = ALU_W'(b_q);
        alu_req.b = ALU_W'(sb_q);
        alu_req.c = ALU_W'(nb_q);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // Candidate choice of the fit search for the block being visited.
  always_comb begin
    case (policy_q)
      FP_BEST:  take = fit && (!found_q || (size_rd < pick_size_q));
      FP_WORST: take = fit && (!found_q || (size_rd > pick_size_q));
      default:  take = fit;
    endcase
    corrupt_a = (count_q >= NUNITS_U) || (cur_q >= NUNITS_U) ||
                (size_rd < HDR_U) || !alu_rsp.lt;
  end

  always_comb begin
    state_d     = state_q;
    free_head_d = free_head_q;
    policy_d    = policy_q;
    clr_d       = clr_q;
    reinit_d    = reinit_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    first_d     = first_q;
    left_d      = left_q;
    split_d     = split_q;
    count_d     = count_q;
    op_d        = op_q;
    zone_d      = zone_q;
    want_d      = want_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    pick_d      = pick_q;
    pick_prev_d = pick_prev_q;
    pick_size_d = pick_size_q;
    nxp_d       = nxp_q;
    link_d      = link_q;
    real_d      = real_q;
    b_d         = b_q;
    sb_d        = sb_q;
    nb_d        = nb_q;
    p_d         = p_q;
    sp_d        = sp_q;
    res_addr_d  = res_addr_q;
    res_size_d  = res_size_q;
    res_st_d    = res_st_q;
    out_addr_d  = out_addr_q;
    out_size_d  = out_size_q;
    out_st_d    = out_st_q;
    size_we     = 1'b0;
    next_we     = 1'b0;
    size_waddr  = '0;
    next_waddr  = '0;
    size_wdata  = '0;
    next_wdata  = '0;
    raddr       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_valid_i) begin
      policy_d = cfg_data_i;
    end

    case (state_q)
      S_CLEAR: begin
        size_we    = 1'b1;
        next_we    = 1'b1;
        size_waddr = clr_q;
        next_waddr = clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == IW'(NUNITS - 1)) begin
          state_d = S_INIT;
        end
      end

      S_INIT: begin
        size_we     = 1'b1;
        next_we     = 1'b1;
        size_waddr  = HDR_U[IW-1:0];
        next_waddr  = HDR_U[IW-1:0];
        size_wdata  = NUNITS_U - HDR_U;
        free_head_d = HDR_U;
        if (reinit_q) begin
          policy_d = FP_FIRST;
          reinit_d = 1'b0;
          state_d  = S_RESP;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = opcode_e'(opcode_i);
          zone_d     = zone_address_i;
          res_addr_d = '0;
          res_size_d = '0;
          res_st_d   = ST_OK;
          want_d     = ((ALU_W'(request_size_i) + ALU_W'(ALIGN_BYTES - 1)) >> SH) +
                       ALU_W'(HDR);
          cur_d      = free_head_q;
          prev_d     = '0;
          found_d    = 1'b0;
          count_d    = '0;
          case (opcode_e'(opcode_i))
            OP_ALLOC:  state_d = (free_head_q == '0) ? S_A_END : S_A_READ;
            OP_REINIT: begin
              reinit_d = 1'b1;
              state_d  = S_INIT;
            end
            default:   state_d = S_F_START;
          endcase
        end
      end

      // ---------------- allocate ----------------
      S_A_READ: begin
        raddr   = cur_q[IW-1:0];
        state_d = S_A_CHK;
      end

      S_A_CHK: begin
        if (corrupt_a) begin
          res_st_d = ST_CORRUPT;
          state_d  = S_RESP;
        end else begin
          if (take) begin
            found_d     = 1'b1;
            pick_d      = cur_q;
            pick_prev_d = prev_q;
            pick_size_d = size_rd;
          end
          if (fit && (policy_q != FP_BEST) && (policy_q != FP_WORST)) begin
            state_d = S_A_PICK;
          end else if ((next_rd != '0) && ((next_rd < HDR_U) || (next_rd >= NUNITS_U))) begin
            res_st_d = ST_CORRUPT;
            state_d  = S_RESP;
          end else begin
            prev_d  = cur_q;
            cur_d   = next_rd;
            count_d = count_q + 1'b1;
            state_d = (next_rd == '0) ? S_A_END : S_A_READ;
          end
        end
      end

      S_A_END: begin
        if (found_q) begin
          state_d = S_A_PICK;
        end else begin
          res_st_d = ST_NOFIT;
          state_d  = S_RESP;
        end
      end

      S_A_PICK: begin
        raddr   = pick_q[IW-1:0];
        state_d = S_A_SPLIT;
      end

      S_A_SPLIT: begin
        nxp_d   = next_rd;
        split_d = alu_rsp.lt;
        state_d = S_A_W1;
      end

      S_A_W1: begin
        if (split_q) begin
          size_we    = 1'b1;
          next_we    = 1'b1;
          size_waddr = nf[IW-1:0];
          next_waddr = nf[IW-1:0];
          size_wdata = pick_size_q - want_q[UW-1:0];
          next_wdata = nxp_q;
          link_d     = nf;
          real_d     = want_q[UW-1:0];
        end else begin
          link_d = nxp_q;
          real_d = pick_size_q;
        end
        state_d = S_A_W2;
      end

      S_A_W2: begin
        if (pick_prev_q == '0) begin
          free_head_d = link_q;
        end else begin
          next_we    = 1'b1;
          next_waddr = pick_prev_q[IW-1:0];
          next_wdata = link_q;
        end
        size_we    = 1'b1;
        size_waddr = pick_q[IW-1:0];
        size_wdata = real_q;
        res_addr_d = 16'(32'(pick_q + HDR_U) << SH);
        state_d    = S_RESP;
      end

      // ---------------- free and get-size ----------------
      S_F_START: begin
        b_d   = UW'(zone_units - 17'(HDR));
        raddr = b_d[IW-1:0];
        if ((op_q == OP_FREE) && (zone_q == '0)) begin
          state_d = S_RESP;
        end else if ((32'(zone_q) < 32'(ZMIN)) || (32'(zone_q) > 32'(ARENA_BYTES))) begin
          res_st_d = ST_OUTZONE;
          state_d  = S_RESP;
        end else if (zone_q[SH-1:0] != '0) begin
          res_st_d = ST_INVALID;
          state_d  = S_RESP;
        end else begin
          state_d = S_F_B;
        end
      end

      S_F_B: begin
        sb_d = size_rd;
        if (size_rd < HDR_U) begin
          res_st_d = ST_INVALID;
          state_d  = S_RESP;
        end else if (op_q == OP_SIZE) begin
          res_size_d = (usable_bytes > (UW+SH)'(16'hFFFF)) ? 16'hFFFF : usable_bytes[15:0];
          state_d    = S_RESP;
        end else if ((free_head_q == '0) || (free_head_q > b_q)) begin
          // New list head: link to the old head, then try the right merge.
          next_we     = 1'b1;
          next_waddr  = b_q[IW-1:0];
          next_wdata  = free_head_q;
          nb_d        = free_head_q;
          free_head_d = b_q;
          left_d      = 1'b0;
          state_d     = S_M_RD;
        end else begin
          p_d     = free_head_q;
          first_d = 1'b1;
          count_d = '0;
          state_d = S_F_RD;
        end
      end

      S_F_RD: begin
        raddr   = p_q[IW-1:0];
        state_d = S_F_EV;
      end

      S_F_EV: begin
        sp_d    = size_rd;
        nxp_d   = next_rd;
        first_d = 1'b0;
        if (first_q && ((p_q == b_q) || (!alu_rsp.lt && !alu_rsp.eq))) begin
          res_st_d = ST_ALREADY;
          state_d  = S_RESP;
        end else if ((next_rd == '0) || (next_rd > b_q)) begin
          state_d = S_F_FIN;
        end else if ((size_rd < HDR_U) || (next_rd >= NUNITS_U) || (count_q >= NUNITS_U)) begin
          res_st_d = ST_CORRUPT;
          state_d  = S_RESP;
        end else begin
          p_d     = next_rd;
          count_d = count_q + 1'b1;
          state_d = S_F_RD;
        end
      end

      S_F_FIN: begin
        if ((p_q >= NUNITS_U) || (sp_q < HDR_U)) begin
          res_st_d = ST_CORRUPT;
          state_d  = S_RESP;
        end else if ((p_q == b_q) || (!alu_rsp.lt && !alu_rsp.eq)) begin
          res_st_d = ST_ALREADY;
          state_d  = S_RESP;
        end else begin
          next_we    = 1'b1;
          next_waddr = b_q[IW-1:0];
          next_wdata = nxp_q;
          nb_d       = nxp_q;
          state_d    = S_F_L2;
        end
      end

      S_F_L2: begin
        next_we    = 1'b1;
        next_waddr = p_q[IW-1:0];
        next_wdata = b_q;
        left_d     = 1'b1;
        state_d    = S_M_RD;
      end

      S_M_RD: begin
        raddr = nb_q[IW-1:0];
        if ((nb_q != '0) && (nb_q < NUNITS_U)) begin
          state_d = S_M_CHK;
        end else begin
          state_d = left_q ? S_M_LEFT : S_RESP;
        end
      end

      S_M_CHK: begin
        if (alu_rsp.eq) begin
          size_we    = 1'b1;
          next_we    = 1'b1;
          size_waddr = b_q[IW-1:0];
          next_waddr = b_q[IW-1:0];
          size_wdata = sb_q + size_rd;
          next_wdata = next_rd;
          sb_d       = sb_q + size_rd;
          nb_d       = next_rd;
        end
        state_d = left_q ? S_M_LEFT : S_RESP;
      end

      S_M_LEFT: begin
        if (alu_rsp.eq) begin
          size_we    = 1'b1;
          next_we    = 1'b1;
          size_waddr = p_q[IW-1:0];
          next_waddr = p_q[IW-1:0];
          size_wdata = sp_q + sb_q;
          next_wdata = nb_q;
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_size_d  = res_size_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      free_head_q <= HDR_U;
      policy_q    <= FP_FIRST;
      clr_q       <= '0;
      reinit_q    <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      first_q     <= 1'b0;
      left_q      <= 1'b0;
      split_q     <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      policy_q    <= policy_d;
      clr_q       <= clr_d;
      reinit_q    <= reinit_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      first_q     <= first_d;
      left_q      <= left_d;
      split_q     <= split_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    zone_q      <= zone_d;
    want_q      <= want_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    pick_q      <= pick_d;
    pick_prev_q <= pick_prev_d;
    pick_size_q <= pick_size_d;
    nxp_q       <= nxp_d;
    link_q      <= link_d;
    real_q      <= real_d;
    b_q         <= b_d;
    sb_q        <= sb_d;
    nb_q        <= nb_d;
    p_q         <= p_d;
    sp_q        <= sp_d;
    res_addr_q  <= res_addr_d;
    res_size_q  <= res_size_d;
    res_st_q    <= res_st_d;
    out_addr_q  <= out_addr_d;
    out_size_q  <= out_size_d;
    out_st_q    <= out_st_d;
  end

  // A taken request keeps the block busy for at least the next cycle.
  `FLHA_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "accepted twice")
  // The list head always names a unit inside the arena, or none.
  `FLHA_ASSERT(a_head_in_arena, free_head_q < NUNITS_U, "free list head outside arena")
  // Only defined status codes leave the block.
  `FLHA_ASSERT_ALWAYS(a_status_code, out_valid_o |-> (status_o <= 3'(ST_CORRUPT)), "bad status")
  // Returned zones and sizes are whole units, but for a size saturated at 16'hFFFF.
  `FLHA_ASSERT(a_aligned_result,
      out_valid_o |-> ((result_address_o[SH-1:0] == '0) && (result_size_o[SH-1:0] == '0)
                       || (result_size_o == 16'hFFFF)), "result not aligned")

endmodule

[test/free_list_heap_allocator_tb.sv]
// Self-checking testbench of the free-list heap allocator: directed table, then random traffic.
// Depends on flha_pkg and the free_list_heap_allocator RTL with the files that it depends on.
`timescale 1ns / 1ps

module free_list_heap_allocator_tb;
  import flha_pkg::*;

  localparam int NU = 65536 / 16;  // Units in the arena at the default parameters.

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] size;
    status_e     status;
  } heap_word_t;

  typedef struct {
    opcode_e     op;
    logic [15:0] req;
    logic [15:0] zone;
    bit          typed;   // Expected word is given in the row.
    heap_word_t  want;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = '0;
  logic [15:0] request_size_i = '0;
  logic [15:0] zone_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] result_address_o;
  logic [15:0] result_size_o;
  logic [2:0]  status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = '0;

  // Our own copy of the header store, the free-list head and the fit policy.
  int unsigned hdr_size [NU];
  int unsigned hdr_next [NU];
  int unsigned list_head;
  logic [1:0]  fit_mode;

  heap_word_t  pending_words[$];
  logic [15:0] live_zones[$];
  int          error_count = 0;
  bit          calm = 1'b0;  // No idling on either side when set.
  int          out_stall = 0;

  free_list_heap_allocator i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // The receiver stalls in random bursts.
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_ready_i = 1'b0;
      out_stall--;
    end else if (!calm && $urandom_range(9) == 0) begin
      out_ready_i = 1'b0;
      out_stall = $urandom_range(6);
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // Every word leaving the block is compared with the oldest expectation.
  always @(posedge clk_i) begin
    heap_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $error("result word with no expectation waiting");
        error_count++;
      end else begin
        exp_w = pending_words.pop_front();
        if (result_address_o !== exp_w.addr) begin
          $error("result_address expected %0d actual %0d", exp_w.addr, result_address_o);
          error_count++;
        end
        if (result_size_o !== exp_w.size) begin
          $error("result_size expected %0d actual %0d", exp_w.size, result_size_o);
          error_count++;
        end
        if (status_o !== exp_w.status) begin
          $error("status expected %0d actual %0d", exp_w.status, status_o);
          error_count++;
        end
      end
    end
  end

  function automatic void rebuild_arena();
    list_head = 1;
    hdr_size[1] = NU - 1;
    hdr_next[1] = 0;
  endfunction

  function automatic status_e heap_alloc(int unsigned req, output logic [15:0] addr);
    int unsigned want, cur, prev, pick, pick_prev, pick_size, count, s, nxt, link, real_sz;
    bit found;
    want = (req + 15) / 16 + 1;
    cur = list_head; prev = 0; pick = 0; pick_prev = 0; pick_size = 0; count = 0;
    found = 1'b0;
    addr = '0;
    while (cur != 0) begin
      count++;
      if (count > NU || cur >= NU) return ST_CORRUPT;
      s = hdr_size[cur];
      if (s < 1 || s > NU - cur) return ST_CORRUPT;
      if (s >= want) begin
        if (fit_mode == FP_BEST) begin
          if (!found || s < pick_size) begin
            found = 1; pick = cur; pick_prev = prev; pick_size = s;
          end
        end else if (fit_mode == FP_WORST) begin
          if (!found || s > pick_size) begin
            found = 1; pick = cur; pick_prev = prev; pick_size = s;
          end
        end else begin
          found = 1; pick = cur; pick_prev = prev; pick_size = s;
          break;
        end
      end
      nxt = hdr_next[cur];
      if (nxt >= NU) return ST_CORRUPT;
      prev = cur;
      cur = nxt;
    end
    if (!found) return ST_NOFIT;
    nxt = hdr_next[pick];
    // Split only when the remainder is larger than a bare header.
    if (pick_size > want + 1) begin
      hdr_size[pick + want] = pick_size - want;
      hdr_next[pick + want] = nxt;
      link = pick + want;
      real_sz = want;
    end else begin
      link = nxt;
      real_sz = pick_size;
    end
    if (pick_prev == 0) list_head = link;
    else hdr_next[pick_prev] = link;
    hdr_size[pick] = real_sz;
    addr = 16'((pick + 1) * 16);
    return ST_OK;
  endfunction

  function automatic status_e zone_unit(int unsigned zone, output int unsigned b);
    b = 0;
    if (zone < 16) return ST_OUTZONE;
    if (zone % 16 != 0) return ST_INVALID;
    b = zone / 16 - 1;
    if (hdr_size[b] < 1) return ST_INVALID;
    return ST_OK;
  endfunction

  function automatic void join_right(int unsigned b);
    int unsigned nx;
    nx = hdr_next[b];
    if (nx != 0 && nx < NU && b + hdr_size[b] == nx) begin
      hdr_size[b] += hdr_size[nx];
      hdr_next[b] = hdr_next[nx];
    end
  endfunction

  function automatic int unsigned size_at(int unsigned u);
    return (u < NU) ? hdr_size[u] : 0;
  endfunction

  function automatic status_e heap_free(int unsigned zone);
    int unsigned b, p, nx, count;
    status_e st;
    count = 0;
    if (zone == 0) return ST_OK;
    st = zone_unit(zone, b);
    if (st != ST_OK) return st;
    if (list_head == 0 || list_head > b) begin
      hdr_next[b] = list_head;
      list_head = b;
      join_right(b);
      return ST_OK;
    end
    p = list_head;
    if (p == b || b < p + size_at(p)) return ST_ALREADY;
    forever begin
      nx = (p < NU) ? hdr_next[p] : 0;
      if (nx == 0 || nx > b) break;
      count++;
      if (size_at(p) < 1 || nx >= NU || count > NU) return ST_CORRUPT;
      p = nx;
    end
    if (p >= NU || hdr_size[p] < 1) return ST_CORRUPT;
    if (p == b || b < p + hdr_size[p]) return ST_ALREADY;
    hdr_next[b] = hdr_next[p];
    hdr_next[p] = b;
    join_right(b);
    // Merge with the left neighbor when the two touch.
    if (p + hdr_size[p] == b) begin
      hdr_size[p] += hdr_size[b];
      hdr_next[p] = hdr_next[b];
    end
    return ST_OK;
  endfunction

  function automatic heap_word_t heap_predict(opcode_e op, logic [15:0] req,
                                              logic [15:0] zone);
    heap_word_t w;
    int unsigned b, bytes;
    w = '{addr: '0, size: '0, status: ST_OK};
    case (op)
      OP_ALLOC: w.status = heap_alloc(req, w.addr);
      OP_FREE:  w.status = heap_free(zone);
      OP_SIZE: begin
        w.status = zone_unit(zone, b);
        if (w.status == ST_OK) begin
          bytes = (hdr_size[b] - 1) * 16;
          w.size = (bytes > 16'hFFFF) ? 16'hFFFF : bytes[15:0];
        end
      end
      default: begin
        rebuild_arena();
        fit_mode = FP_FIRST;
      end
    endcase
    return w;
  endfunction

  // Offers one request word; the expectation is either typed in or predicted.
  task automatic issue(opcode_e op, logic [15:0] req, logic [15:0] zone, bit typed,
                       heap_word_t typed_w, output heap_word_t got);
    int gap;
    if (!calm && $urandom_range(4) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i = op;
    request_size_i = req;
    zone_address_i = zone;
    do @(posedge clk_i); while (!in_ready_o);
    got = heap_predict(op, req, zone);
    pending_words.push_back(typed ? typed_w : got);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Register writes happen only once the block has delivered every result.
  task automatic set_fit(logic [1:0] mode);
    wait (pending_words.size() == 0);
    repeat (10) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    fit_mode = mode;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    table_row_t rows[$];
    heap_word_t got, none;
    logic [1:0] modes[5];
    int r, k, idx;
    logic [15:0] z;
    opcode_e op;

    none = '{addr: '0, size: '0, status: ST_OK};
    modes = '{FP_BEST, FP_WORST, 2'd3, FP_FIRST, FP_WORST};
    for (int u = 0; u < NU; u++) begin
      hdr_size[u] = 0;
      hdr_next[u] = 0;
    end
    rebuild_arena();
    fit_mode = FP_FIRST;

    // Directed rows: extremes, every operation and the named special cases.
    rows = '{
      '{OP_SIZE,  16'd0,     16'd32,    1, '{16'd0,  16'd65504, ST_OK}},
      '{OP_FREE,  16'd0,     16'd0,     1, '{16'd0,  16'd0,     ST_OK}},
      '{OP_SIZE,  16'd0,     16'd0,     1, '{16'd0,  16'd0,     ST_OUTZONE}},
      '{OP_FREE,  16'd0,     16'd15,    1, '{16'd0,  16'd0,     ST_OUTZONE}},
      '{OP_SIZE,  16'd0,     16'd16,    1, '{16'd0,  16'd0,     ST_INVALID}},
      '{OP_FREE,  16'd0,     16'hFFFF,  1, '{16'd0,  16'd0,     ST_INVALID}},
      '{OP_SIZE,  16'd0,     16'd33,    1, '{16'd0,  16'd0,     ST_INVALID}},
      '{OP_ALLOC, 16'hFFFF,  16'd0,     1, '{16'd0,  16'd0,     ST_NOFIT}},
      '{OP_ALLOC, 16'd0,     16'hFFFF,  1, '{16'd32, 16'd0,     ST_OK}},
      '{OP_ALLOC, 16'd1,     16'd0,     0, none},
      '{OP_ALLOC, 16'd16,    16'd0,     0, none},
      '{OP_ALLOC, 16'd17,    16'd0,     0, none},
      '{OP_ALLOC, 16'd100,   16'd0,     0, none},
      '{OP_SIZE,  16'd0,     16'd32,    1, '{16'd0,  16'd0,     ST_OK}},
      '{OP_FREE,  16'd0,     16'd32,    1, '{16'd0,  16'd0,     ST_OK}},
      '{OP_FREE,  16'd0,     16'd32,    1, '{16'd0,  16'd0,     ST_ALREADY}},
      '{OP_FREE,  16'd0,     16'd64,    0, none},
      '{OP_FREE,  16'd0,     16'd64,    0, none},
      '{OP_FREE,  16'd0,     16'hFFF0,  0, none},
      '{OP_ALLOC, 16'd65503, 16'd0,     0, none},
      '{OP_REINIT,16'hFFFF,  16'hFFFF,  1, '{16'd0,  16'd0,     ST_OK}},
      '{OP_SIZE,  16'd0,     16'd32,    1, '{16'd0,  16'd65504, ST_OK}},
      '{OP_ALLOC, 16'd65488, 16'd0,     1, '{16'd32, 16'd0,     ST_OK}},
      '{OP_ALLOC, 16'd0,     16'd0,     1, '{16'd0,  16'd0,     ST_NOFIT}},
      '{OP_REINIT,16'd0,     16'd0,     1, '{16'd0,  16'd0,     ST_OK}}
    };

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    set_fit(FP_FIRST);
    foreach (rows[i]) issue(rows[i].op, rows[i].req, rows[i].zone, rows[i].typed,
                            rows[i].want, got);

    // Random phases, one fit policy each; the last phase runs without idling.
    for (int ph = 0; ph < 5; ph++) begin
      set_fit(modes[ph]);
      live_zones.delete();
      calm = (ph == 4);
      for (k = 0; k < 260; k++) begin
        r = $urandom_range(99);
        if (live_zones.size() > 40 && r < 50) r = 50;
        if (r < 50 || live_zones.size() == 0) begin
          r = $urandom_range(99);
          if (r < 70) z = 16'($urandom_range(512));
          else if (r < 92) z = 16'($urandom_range(4095));
          else z = 16'($urandom);
          issue(OP_ALLOC, z, 16'($urandom), 0, none, got);
          if (got.status == ST_OK) live_zones.push_back(got.addr);
        end else if (r < 78) begin
          idx = $urandom_range(live_zones.size() - 1);
          issue(OP_FREE, 16'($urandom), live_zones[idx], 0, none, got);
          if ($urandom_range(3) != 0) live_zones.delete(idx);
        end else if (r < 88) begin
          idx = $urandom_range(live_zones.size() - 1);
          issue(OP_SIZE, 16'($urandom), live_zones[idx], 0, none, got);
        end else if (r < 99) begin
          // Stray pointers, either aligned into the arena or any value at all.
          z = $urandom_range(1) ? {12'($urandom_range(1, 4095)), 4'b0} : 16'($urandom);
          op = $urandom_range(1) ? OP_FREE : OP_SIZE;
          issue(op, 16'($urandom), z, 0, none, got);
        end else begin
          issue(OP_REINIT, 16'($urandom), 16'($urandom), 0, none, got);
          live_zones.delete();
        end
      end
    end

    wait (pending_words.size() == 0);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Leftover expectations at the end count as failures through the wait above:
  // the run then ends only by the time limit, which reports the failure.

endmodule

[filelist.f]
+incdir+rtl
rtl/flha_pkg.sv
rtl/flha_ram.sv
rtl/flha_alu.sv
rtl/free_list_heap_allocator.sv
test/free_list_heap_allocator_tb.sv
